### rtl/bnc_pkg.sv
// Shared types, constants and helpers of the binary 3x3 neighbor count block.
`timescale 1ns / 1ps

package bnc_pkg;

    localparam int unsigned MAX_WIDTH_DEF  = 1024;
    localparam int unsigned MAX_HEIGHT_DEF = 1024;

    localparam int unsigned CFG_DATA_W = 11;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned COUNT_W    = 4;
    localparam int unsigned COL_BITS   = 3;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx REG_FRAME_WIDTH  = t_cfg_idx'(0);
    localparam t_cfg_idx REG_FRAME_HEIGHT = t_cfg_idx'(1);

    localparam logic [CFG_DATA_W-1:0] DIM_RESET = CFG_DATA_W'(64);

    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_DRAIN = 1'b1;

    // Control carried by one request from the position stage to the window stage.
    typedef struct packed {
        logic emit;
        logic up_ok;
        logic mid_ok;
        logic x;
        logic top_edge;
        logic bottom_edge;
        logic left_edge;
        logic right_edge;
        logic eor;
        logic eof;
    } t_s1_ctl;

    function automatic logic [31:0] clamp_dim(input logic [CFG_DATA_W-1:0] v,
                                              input int unsigned hi);
        logic [31:0] v32;
        v32 = 32'(v);
        if (v32 == 32'd0) begin
            return 32'd1;
        end
        if (v32 > hi) begin
            return hi;
        end
        return v32;
    endfunction

endpackage

### rtl/bnc_in_if.sv
// Pixel request channel.
`timescale 1ns / 1ps

interface bnc_in_if;
    logic valid;
    logic ready;
    logic req_type;
    logic pixel;

    modport source (output valid, output req_type, output pixel, input ready);
    modport sink (input valid, input req_type, input pixel, output ready);
endinterface

### rtl/bnc_out_if.sv
// Neighbor count result channel.
`timescale 1ns / 1ps

interface bnc_out_if;
    logic                         valid;
    logic                         ready;
    logic [bnc_pkg::COUNT_W-1:0]  count;
    logic                         end_of_row;
    logic                         end_of_frame;

    modport source (output valid, output count, output end_of_row, output end_of_frame,
                    input ready);
    modport sink (input valid, input count, input end_of_row, input end_of_frame,
                  output ready);
endinterface

### rtl/bnc_cfg_if.sv
// Configuration register write channel.
`timescale 1ns / 1ps

interface bnc_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [bnc_pkg::CFG_IDX_W-1:0]  index;
    logic [bnc_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/bnc_ram.sv
// Generic single write port, single read port RAM with registered read.
`timescale 1ns / 1ps

module bnc_ram #(
    parameter int unsigned WIDTH = 2,
    parameter int unsigned DEPTH = bnc_pkg::MAX_WIDTH_DEF
) (
    input  logic                                     i_clk,
    input  logic                                     i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                         i_wr_data,
    input  logic                                     i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/bnc_cell.sv
// One column cell of the 3x3 window; shifts its column to the next cell.
`timescale 1ns / 1ps

module bnc_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_shift,
    input  logic [bnc_pkg::COL_BITS-1:0]  i_col,
    output logic [bnc_pkg::COL_BITS-1:0]  o_col
);

    logic [bnc_pkg::COL_BITS-1:0] r_col;
    logic [bnc_pkg::COL_BITS-1:0] n_col;

    always_comb begin
        n_col = r_col;
        if (i_shift) begin
            n_col = i_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
        end else begin
            r_col <= n_col;
        end
    end

    assign o_col = r_col;

endmodule

### rtl/binary_3x3_neighbor_count.sv
// Top level: 3x3 set-pixel count over a binary raster image, one pixel per cycle.
// Throughput: one request per cycle; stalls only when the result register is full.
// Latency: the result of a pixel leaves with the request frame_width+1 requests later; it is
// registered in the window stage (with the line buffer read), then in the result register.
// Reset (synchronous, active low) clears positions, window and pipeline, sets both sizes to 64.
// The line buffer RAM is not cleared: rows not yet written in the frame read as zero.
`timescale 1ns / 1ps

module binary_3x3_neighbor_count #(
    parameter int unsigned MAX_WIDTH  = bnc_pkg::MAX_WIDTH_DEF,
    parameter int unsigned MAX_HEIGHT = bnc_pkg::MAX_HEIGHT_DEF
) (
    input logic        i_clk,
    input logic        i_rst_n,
    bnc_in_if.sink     i_pix,
    bnc_cfg_if.sink    i_cfg,
    bnc_out_if.source  o_res
);

    localparam int unsigned COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int unsigned WID_W = $clog2(MAX_WIDTH + 1);
    localparam int unsigned HGT_W = $clog2(MAX_HEIGHT + 1);
    localparam int unsigned ROW_W = $clog2(MAX_HEIGHT + 2);
    localparam int unsigned LB_UP  = 0;
    localparam int unsigned LB_MID = 1;

    // Configuration, stored already clamped to the legal range.
    logic [WID_W-1:0] r_width,  n_width;
    logic [HGT_W-1:0] r_height, n_height;

    // Frame positions of the next request and the next result.
    logic [COL_W-1:0] r_in_col,  n_in_col;
    logic [ROW_W-1:0] r_in_row,  n_in_row;
    logic [COL_W-1:0] r_out_col, n_out_col;
    logic [HGT_W-1:0] r_out_row, n_out_row;

    logic             cfg_fire;
    logic             cfg_dim;
    logic             in_fire;
    logic [WID_W-1:0] in_col_inc;
    logic             in_col_last;
    logic [WID_W-1:0] out_col_inc;
    logic [HGT_W-1:0] out_row_inc;
    bnc_pkg::t_s1_ctl s1_ctl;

    // Window stage.
    logic                         r_s1_v;
    bnc_pkg::t_s1_ctl             r_s1;
    logic [COL_W-1:0]             r_s1_addr;
    logic                         r_fwd;
    logic [1:0]                   r_fwd_data;
    logic [1:0]                   ram_q;
    logic [1:0]                   lb_eff;
    logic [1:0]                   lb_wr_data;
    logic                         mid_bit;
    logic                         up_bit;
    logic [bnc_pkg::COL_BITS-1:0] new_col;
    logic [bnc_pkg::COL_BITS-1:0] win_in  [2];
    logic [bnc_pkg::COL_BITS-1:0] win_col [2];
    logic [8:0]                   win_bits;
    logic [bnc_pkg::COUNT_W-1:0]  win_count;
    logic                         s1_adv;

    // Result register.
    logic                         r_o_v;
    logic [bnc_pkg::COUNT_W-1:0]  r_o_count;
    logic                         r_o_eor;
    logic                         r_o_eof;
    logic                         out_free;

    assign cfg_fire = i_cfg.valid && i_cfg.ready;
    assign cfg_dim  = (i_cfg.index == bnc_pkg::REG_FRAME_WIDTH) ||
                      (i_cfg.index == bnc_pkg::REG_FRAME_HEIGHT);
    assign in_fire  = i_pix.valid && i_pix.ready;

    assign out_free = !r_o_v || o_res.ready;
    assign s1_adv   = r_s1_v && (!r_s1.emit || out_free);

    assign i_cfg.ready = 1'b1;
    assign i_pix.ready = !r_s1_v || s1_adv;

    // Position stage: decide emission and edge masks from the current positions.
    always_comb begin
        in_col_inc  = WID_W'(r_in_col) + WID_W'(1);
        in_col_last = in_col_inc >= r_width;
        out_col_inc = WID_W'(r_out_col) + WID_W'(1);
        out_row_inc = r_out_row + HGT_W'(1);

        s1_ctl.emit   = (r_in_row >= ROW_W'(2)) ||
                        ((r_in_row == ROW_W'(1)) && (r_in_col != '0));
        s1_ctl.up_ok  = r_in_row >= ROW_W'(2);
        s1_ctl.mid_ok = r_in_row >= ROW_W'(1);
        // Requests past the last row of the frame enter as zero pixels.
        s1_ctl.x      = (i_pix.req_type == bnc_pkg::REQ_PIXEL) &&
                        (r_in_row < ROW_W'(r_height)) && i_pix.pixel;
        s1_ctl.top_edge    = r_out_row == '0;
        s1_ctl.bottom_edge = out_row_inc >= r_height;
        s1_ctl.left_edge   = r_out_col == '0;
        s1_ctl.right_edge  = out_col_inc >= r_width;
        s1_ctl.eor         = s1_ctl.right_edge;
        s1_ctl.eof         = s1_ctl.right_edge && s1_ctl.bottom_edge;
    end

    always_comb begin
        n_width   = r_width;
        n_height  = r_height;
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (cfg_fire && cfg_dim) begin
            if (i_cfg.index == bnc_pkg::REG_FRAME_WIDTH) begin
                n_width = WID_W'(bnc_pkg::clamp_dim(i_cfg.data, MAX_WIDTH));
            end else begin
                n_height = HGT_W'(bnc_pkg::clamp_dim(i_cfg.data, MAX_HEIGHT));
            end
            n_in_col  = '0;
            n_in_row  = '0;
            n_out_col = '0;
            n_out_row = '0;
        end else if (in_fire) begin
            if (s1_ctl.emit && s1_ctl.eof) begin
                n_in_col  = '0;
                n_in_row  = '0;
                n_out_col = '0;
                n_out_row = '0;
            end else begin
                if (in_col_last) begin
                    n_in_col = '0;
                    n_in_row = r_in_row + ROW_W'(1);
                end else begin
                    n_in_col = COL_W'(in_col_inc);
                end
                if (s1_ctl.emit) begin
                    if (s1_ctl.eor) begin
                        n_out_col = '0;
                        n_out_row = out_row_inc;
                    end else begin
                        n_out_col = COL_W'(out_col_inc);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= WID_W'(bnc_pkg::clamp_dim(bnc_pkg::DIM_RESET, MAX_WIDTH));
            r_height  <= HGT_W'(bnc_pkg::clamp_dim(bnc_pkg::DIM_RESET, MAX_HEIGHT));
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else begin
            r_width   <= n_width;
            r_height  <= n_height;
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
        end
    end

    // Line buffer: bit 1 holds the previous row, bit 0 the row before it.
    bnc_ram #(
        .WIDTH (2),
        .DEPTH (MAX_WIDTH)
    ) u_line_buf (
        .i_clk     (i_clk),
        .i_wr_en   (s1_adv),
        .i_wr_addr (r_s1_addr),
        .i_wr_data (lb_wr_data),
        .i_rd_en   (in_fire),
        .i_rd_addr (r_in_col),
        .o_rd_data (ram_q)
    );

    // With a one-pixel row the same entry is read while it is being written,
    // so the written value is forwarded instead of the stale read data.
    always_comb begin
        lb_eff     = r_fwd ? r_fwd_data : ram_q;
        mid_bit    = lb_eff[LB_MID] & r_s1.mid_ok;
        up_bit     = lb_eff[LB_UP] & r_s1.up_ok;
        new_col    = {r_s1.x, mid_bit, up_bit};
        lb_wr_data = {r_s1.x, mid_bit};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_fwd  <= 1'b0;
        end else begin
            if (in_fire) begin
                r_s1_v <= 1'b1;
                r_fwd  <= s1_adv && (r_s1_addr == r_in_col);
            end else if (s1_adv) begin
                r_s1_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1       <= s1_ctl;
            r_s1_addr  <= r_in_col;
            r_fwd_data <= lb_wr_data;
        end
    end

    // Window: two column cells hold the older columns and shift left per request;
    // the incoming column completes the 3x3 block on the right.
    always_comb begin
        win_in[1] = new_col;
        win_in[0] = win_col[1];
    end

    for (genvar k = 0; k < 2; k++) begin : g_cell
        bnc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (s1_adv),
            .i_col   (win_in[k]),
            .o_col   (win_col[k])
        );
    end

    // Count over the shifted window, with rows and columns outside the frame masked.
    always_comb begin
        win_bits = {new_col, win_col[1], win_col[0]};
        if (r_s1.top_edge) begin
            win_bits = win_bits & 9'b110_110_110;
        end
        if (r_s1.bottom_edge) begin
            win_bits = win_bits & 9'b011_011_011;
        end
        if (r_s1.left_edge) begin
            win_bits = win_bits & 9'b111_111_000;
        end
        if (r_s1.right_edge) begin
            win_bits = win_bits & 9'b000_111_111;
        end
        win_count = '0;
        for (int i = 0; i < 9; i++) begin
            win_count = win_count + bnc_pkg::COUNT_W'(win_bits[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else begin
            if (s1_adv && r_s1.emit) begin
                r_o_v <= 1'b1;
            end else if (o_res.ready) begin
                r_o_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1.emit) begin
            r_o_count <= win_count;
            r_o_eor   <= r_s1.eor;
            r_o_eof   <= r_s1.eof;
        end
    end

    assign o_res.valid        = r_o_v;
    assign o_res.count        = r_o_count;
    assign o_res.end_of_row   = r_o_eor;
    assign o_res.end_of_frame = r_o_eof;

`ifndef SYNTHESIS
    a_eof_is_eor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_v && r_o_eof |-> r_o_eor)
        else $error("end of frame result without end of row");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_v |-> (r_o_count <= bnc_pkg::COUNT_W'(9)))
        else $error("neighbor count above nine");

    a_in_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        WID_W'(r_in_col) < r_width)
        else $error("input column outside the row");

    a_out_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (WID_W'(r_out_col) < r_width) && (r_out_row < r_height))
        else $error("result position outside the frame");

    a_stall_holds_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_v && !s1_adv |=> r_s1_v && $stable(r_s1_addr))
        else $error("window stage request lost while stalled");
`endif

endmodule

### dv/tb_top.sv
// Self-checking testbench for the binary 3x3 neighbor count block.
`timescale 1ns / 1ps

module tb_top;

    localparam int unsigned LINE_DEPTH    = bnc_pkg::MAX_WIDTH_DEF;
    localparam int unsigned ROW_LIMIT     = bnc_pkg::MAX_HEIGHT_DEF;
    localparam int unsigned ROW_CEIL      = 2047;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned END_CYCLES    = 16;
    localparam int unsigned LIMIT_CYCLES  = 600000;
    localparam int unsigned RANDOM_REQS   = 260;
    localparam int unsigned CALM_AFTER    = 200;
    localparam int unsigned SIZE_PROBE    = 60;

    localparam bnc_pkg::t_cfg_idx REG_SPARE_2 = bnc_pkg::t_cfg_idx'(2);
    localparam bnc_pkg::t_cfg_idx REG_SPARE_3 = bnc_pkg::t_cfg_idx'(3);

    // Window bit groups; bit 0 is the top of the oldest column.
    localparam logic [8:0] TOP_ROW_BITS    = 9'h049;
    localparam logic [8:0] BOTTOM_ROW_BITS = 9'h124;
    localparam logic [8:0] LEFT_COL_BITS   = 9'h007;
    localparam logic [8:0] RIGHT_COL_BITS  = 9'h1C0;

    typedef struct packed {
        logic req_type;
        logic pixel;
    } t_pix_req;

    typedef struct {
        logic [bnc_pkg::COUNT_W-1:0] count;
        logic                        eor;
        logic                        eof;
    } t_box_result;

    logic i_clk;
    logic i_rst_n;

    bnc_in_if  pix_if ();
    bnc_cfg_if cfg_if ();
    bnc_out_if res_if ();

    binary_3x3_neighbor_count i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_if),
        .i_cfg   (cfg_if),
        .o_res   (res_if)
    );

    t_pix_req    pixel_reqs[$];
    t_box_result expected_boxes[$];

    // Predictor state.
    logic [bnc_pkg::CFG_DATA_W-1:0] width_reg;
    logic [bnc_pkg::CFG_DATA_W-1:0] height_reg;
    logic                  upper_row [LINE_DEPTH];
    logic                  mid_row [LINE_DEPTH];
    logic [8:0]            box;
    int unsigned           in_x;
    int unsigned           in_y;
    int unsigned           out_x;
    int unsigned           out_y;

    bit          pix_busy;
    bit          calm_tail;
    int unsigned pix_gap;
    int unsigned sink_gap;
    t_pix_req    next_req;
    int unsigned cycles;
    int unsigned reqs_pushed;
    int unsigned reqs_taken;
    int unsigned results_seen;
    int unsigned reg_writes;
    int unsigned mismatches;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned dim_limit(input logic [bnc_pkg::CFG_DATA_W-1:0] v,
                                              input int unsigned hi);
        if (v == '0) begin
            return 1;
        end
        if (int'(v) > hi) begin
            return hi;
        end
        return int'(v);
    endfunction

    task automatic restart_positions();
        in_x  = 0;
        in_y  = 0;
        out_x = 0;
        out_y = 0;
    endtask

    // Advances the predicted image position by one request and queues the
    // box count that falls out of it, if any.
    task automatic predict_box_count(input logic kind, input logic value);
        int unsigned w;
        int unsigned h;
        logic        x;
        logic [2:0]  column;
        logic [8:0]  keep;
        bit          emit;
        t_box_result res;
        w = dim_limit(width_reg, LINE_DEPTH);
        h = dim_limit(height_reg, ROW_LIMIT);
        if (in_x >= w) begin
            in_x = w - 1;
        end
        x = (kind == bnc_pkg::REQ_PIXEL && in_y < h) ? value : 1'b0;
        column = {x, mid_row[in_x], upper_row[in_x]};
        upper_row[in_x] = mid_row[in_x];
        mid_row[in_x] = x;
        box = {column, box[8:3]};
        emit = (in_y >= 2) || (in_y == 1 && in_x >= 1);
        in_x++;
        if (in_x >= w) begin
            in_x = 0;
            if (in_y < ROW_CEIL) begin
                in_y++;
            end
        end
        if (emit) begin
            keep = '1;
            if (out_y == 0) keep &= ~TOP_ROW_BITS;
            if (out_y + 1 >= h) keep &= ~BOTTOM_ROW_BITS;
            if (out_x == 0) keep &= ~LEFT_COL_BITS;
            if (out_x + 1 >= w) keep &= ~RIGHT_COL_BITS;
            res.count = bnc_pkg::COUNT_W'($countones(box & keep));
            res.eor = (out_x + 1 >= w);
            res.eof = res.eor && (out_y + 1 >= h);
            expected_boxes.push_back(res);
            if (res.eof) begin
                restart_positions();
            end else if (res.eor) begin
                out_x = 0;
                out_y++;
            end else begin
                out_x++;
            end
        end
    endtask

    // Request driver.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pix_if.valid <= 1'b0;
        end else if (!pix_busy) begin
            if (pix_gap > 0) begin
                pix_gap = pix_gap - 1;
                pix_if.valid <= 1'b0;
            end else if (pixel_reqs.size() != 0 && !calm_tail && $urandom_range(0, 9) == 0) begin
                pix_gap = $urandom_range(1, 17) - 1;
                pix_if.valid <= 1'b0;
            end else if (pixel_reqs.size() != 0) begin
                next_req = pixel_reqs.pop_front();
                pix_if.valid    <= 1'b1;
                pix_if.req_type <= next_req.req_type;
                pix_if.pixel    <= next_req.pixel;
                pix_busy = 1'b1;
            end else begin
                pix_if.valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pix_if.valid && pix_if.ready) begin
            predict_box_count(pix_if.req_type, pix_if.pixel);
            reqs_taken++;
            pix_busy = 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && cfg_if.valid && cfg_if.ready) begin
            case (cfg_if.index)
                bnc_pkg::REG_FRAME_WIDTH: begin
                    width_reg = cfg_if.data;
                    restart_positions();
                end
                bnc_pkg::REG_FRAME_HEIGHT: begin
                    height_reg = cfg_if.data;
                    restart_positions();
                end
                default: begin
                end
            endcase
            reg_writes++;
        end
    end

    // Result sink with random back-pressure.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap = sink_gap - 1;
            res_if.ready <= 1'b0;
        end else if (!calm_tail && $urandom_range(0, 11) == 0) begin
            sink_gap = $urandom_range(1, 17) - 1;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    // Result monitor.
    always @(posedge i_clk) begin
        t_box_result want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            results_seen++;
            if (expected_boxes.size() == 0) begin
                $display("%0t: unexpected result count=%0d eor=%0b eof=%0b", $time,
                         res_if.count, res_if.end_of_row, res_if.end_of_frame);
                mismatches++;
            end else begin
                want = expected_boxes.pop_front();
                if (res_if.count !== want.count) begin
                    $display("%0t: count expected %0d actual %0d", $time,
                             want.count, res_if.count);
                    mismatches++;
                end
                if (res_if.end_of_row !== want.eor) begin
                    $display("%0t: end_of_row expected %0b actual %0b", $time,
                             want.eor, res_if.end_of_row);
                    mismatches++;
                end
                if (res_if.end_of_frame !== want.eof) begin
                    $display("%0t: end_of_frame expected %0b actual %0b", $time,
                             want.eof, res_if.end_of_frame);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     expected_boxes.size());
            $display("FAIL binary_3x3_neighbor_count");
            $finish;
        end
    end

    task automatic push_req(input logic kind, input logic value);
        t_pix_req req;
        req.req_type = kind;
        req.pixel    = value;
        pixel_reqs.push_back(req);
        reqs_pushed++;
    endtask

    // Returns once every request is taken and every result has arrived, then
    // lets requests that produce no result settle.
    task automatic wait_drained();
        while (pixel_reqs.size() != 0 || pix_busy || expected_boxes.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input bnc_pkg::t_cfg_idx idx,
                             input logic [bnc_pkg::CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        @(posedge i_clk);
        while (!cfg_if.ready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    // One frame of w x h pixels followed by w+1 trailing requests. At request
    // number cut the stream pauses for a register write: either a spare index,
    // which leaves the frame running, or the width, which abandons it.
    task automatic send_frame(input int unsigned w, input int unsigned h, input int cut);
        int          total;
        int unsigned density;
        logic        value;
        total = w * h + w + 1;
        density = $urandom_range(0, 4);
        for (int i = 0; i < total; i++) begin
            if (i == cut) begin
                wait_drained();
                if ($urandom_range(0, 1) == 0) begin
                    write_reg(($urandom_range(0, 1) == 0) ? REG_SPARE_2 : REG_SPARE_3,
                              bnc_pkg::CFG_DATA_W'($urandom_range(0, 2047)));
                end else begin
                    write_reg(bnc_pkg::REG_FRAME_WIDTH, bnc_pkg::CFG_DATA_W'(w));
                    return;
                end
            end
            value = ($urandom_range(0, 3) < density);
            if (i < w * h) begin
                if ($urandom_range(0, 15) == 0) begin
                    push_req(bnc_pkg::REQ_DRAIN, 1'($urandom_range(0, 1)));
                end else begin
                    push_req(bnc_pkg::REQ_PIXEL, value);
                end
            end else if ($urandom_range(0, 3) == 0) begin
                // A pixel past the end of the frame is treated as a drain.
                push_req(bnc_pkg::REQ_PIXEL, 1'($urandom_range(0, 1)));
            end else begin
                push_req(bnc_pkg::REQ_DRAIN, 1'($urandom_range(0, 1)));
            end
        end
    endtask

    initial begin
        int unsigned wd;
        int unsigned hd;
        int unsigned w;
        int unsigned h;
        int unsigned frames;
        int unsigned random_start;
        int          cut;

        pix_if.valid    = 1'b0;
        pix_if.req_type = bnc_pkg::REQ_PIXEL;
        pix_if.pixel    = 1'b0;
        cfg_if.valid    = 1'b0;
        cfg_if.index    = bnc_pkg::REG_FRAME_WIDTH;
        cfg_if.data     = '0;
        res_if.ready    = 1'b0;
        width_reg  = bnc_pkg::DIM_RESET;
        height_reg = bnc_pkg::DIM_RESET;
        box = '0;
        restart_positions();
        foreach (upper_row[i]) begin
            upper_row[i] = 1'b0;
            mid_row[i]   = 1'b0;
        end
        i_rst_n = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset sizes: two rows of 64 show the first row end, then abandon.
        for (int i = 0; i < 130; i++) begin
            push_req(bnc_pkg::REQ_PIXEL, 1'($urandom_range(0, 1)));
        end
        wait_drained();
        write_reg(REG_SPARE_3, 11'h7FF);
        write_reg(REG_SPARE_2, 11'h000);

        // 3x3 frame of all ones: corners 4, edges 6, center 9.
        write_reg(bnc_pkg::REG_FRAME_WIDTH, 11'd3);
        write_reg(bnc_pkg::REG_FRAME_HEIGHT, 11'd3);
        for (int i = 0; i < 9; i++) begin
            push_req(bnc_pkg::REQ_PIXEL, 1'b1);
        end
        for (int i = 0; i < 4; i++) begin
            push_req(bnc_pkg::REQ_DRAIN, 1'b0);
        end
        wait_drained();

        // Zero sizes saturate to a single pixel; trailing pixels act as drains.
        write_reg(bnc_pkg::REG_FRAME_WIDTH, 11'd0);
        write_reg(bnc_pkg::REG_FRAME_HEIGHT, 11'd0);
        push_req(bnc_pkg::REQ_PIXEL, 1'b1);
        push_req(bnc_pkg::REQ_PIXEL, 1'b1);
        push_req(bnc_pkg::REQ_PIXEL, 1'b0);
        wait_drained();

        // 2x2 frame with a drain inside the frame, which counts as a zero pixel.
        write_reg(bnc_pkg::REG_FRAME_WIDTH, 11'd2);
        write_reg(bnc_pkg::REG_FRAME_HEIGHT, 11'd2);
        push_req(bnc_pkg::REQ_PIXEL, 1'b1);
        push_req(bnc_pkg::REQ_DRAIN, 1'b1);
        push_req(bnc_pkg::REQ_PIXEL, 1'b1);
        push_req(bnc_pkg::REQ_PIXEL, 1'b0);
        push_req(bnc_pkg::REQ_DRAIN, 1'b1);
        push_req(bnc_pkg::REQ_PIXEL, 1'b1);
        push_req(bnc_pkg::REQ_DRAIN, 1'b0);
        wait_drained();

        // Oversized width saturates to the line length, so the first row is
        // still filling and nothing comes out.
        write_reg(bnc_pkg::REG_FRAME_WIDTH, 11'h7FF);
        write_reg(bnc_pkg::REG_FRAME_HEIGHT, 11'd1);
        for (int i = 0; i < SIZE_PROBE; i++) begin
            push_req(bnc_pkg::REQ_PIXEL, 1'($urandom_range(0, 1)));
        end
        wait_drained();

        // Oversized height with one-pixel rows: every result ends a row.
        write_reg(bnc_pkg::REG_FRAME_WIDTH, 11'd1);
        write_reg(bnc_pkg::REG_FRAME_HEIGHT, 11'd1536);
        for (int i = 0; i < SIZE_PROBE; i++) begin
            push_req(bnc_pkg::REQ_PIXEL, 1'($urandom_range(0, 1)));
        end
        wait_drained();

        random_start = reqs_pushed;
        while (reqs_pushed - random_start < RANDOM_REQS) begin
            if (reqs_pushed - random_start >= CALM_AFTER) begin
                calm_tail = 1'b1;
            end
            wd = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
            hd = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
            write_reg(bnc_pkg::REG_FRAME_WIDTH, bnc_pkg::CFG_DATA_W'(wd));
            write_reg(bnc_pkg::REG_FRAME_HEIGHT, bnc_pkg::CFG_DATA_W'(hd));
            w = dim_limit(bnc_pkg::CFG_DATA_W'(wd), LINE_DEPTH);
            h = dim_limit(bnc_pkg::CFG_DATA_W'(hd), ROW_LIMIT);
            frames = $urandom_range(1, 3);
            for (int f = 0; f < frames; f++) begin
                cut = ($urandom_range(0, 5) == 0) ? int'($urandom_range(1, w * h + w)) : -1;
                send_frame(w, h, cut);
            end
            wait_drained();
        end

        wait_drained();
        repeat (END_CYCLES) @(posedge i_clk);
        $display("Sent %0d pixel and drain requests, checked %0d box counts.",
                 reqs_taken, results_seen);
        $display("Applied %0d register writes: zero, small random and oversized frame sizes.",
                 reg_writes);
        if (mismatches == 0) begin
            $display("PASS binary_3x3_neighbor_count");
        end else begin
            $display("FAIL binary_3x3_neighbor_count");
        end
        $finish;
    end

endmodule
